>>> hdl/speech_highpass_postfilter_unit_defines.svh
// assertion macros for the speech high-pass post-filter
// expects clk and arst_n in the scope that includes it
`ifndef SPEECH_HIGHPASS_POSTFILTER_UNIT_DEFINES_SVH
`define SPEECH_HIGHPASS_POSTFILTER_UNIT_DEFINES_SVH

// condition holds, consequence holds in the same cycle
`define SHPF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shpf assertion failed");

// condition holds, consequence holds in the next cycle
`define SHPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shpf assertion failed");

`endif

>>> hdl/shpf_pkg.sv
// shared types and constants of the speech high-pass post-filter
// no dependencies
package shpf_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned COEF_W   = 16;
	localparam int unsigned INDEX_W  = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_word_t;

	typedef struct packed {
		coef_word_t b0;
		coef_word_t b1;
		coef_word_t b2;
		coef_word_t a1;
		coef_word_t a2;
	} coef_t;

	// register indexes on the write port
	localparam logic [INDEX_W-1:0] REG_B0 = 3'd0;
	localparam logic [INDEX_W-1:0] REG_B1 = 3'd1;
	localparam logic [INDEX_W-1:0] REG_B2 = 3'd2;
	localparam logic [INDEX_W-1:0] REG_A1 = 3'd3;
	localparam logic [INDEX_W-1:0] REG_A2 = 3'd4;

	// 100 Hz high-pass in Q13
	localparam coef_word_t RST_B0 = 16'sd7699;
	localparam coef_word_t RST_B1 = -16'sd15398;
	localparam coef_word_t RST_B2 = 16'sd7699;
	localparam coef_word_t RST_A1 = 16'sd15836;
	localparam coef_word_t RST_A2 = -16'sd7667;

endpackage

>>> hdl/shpf_coef_regs.sv
// coefficient register file of the speech high-pass post-filter
// uses shpf_pkg
module shpf_coef_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [shpf_pkg::INDEX_W-1:0]  wr_index,
	input  logic [shpf_pkg::COEF_W-1:0]   wr_data,
	output shpf_pkg::coef_t               coef
);

	shpf_pkg::coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= shpf_pkg::RST_B0;
			coef_q.b1 <= shpf_pkg::RST_B1;
			coef_q.b2 <= shpf_pkg::RST_B2;
			coef_q.a1 <= shpf_pkg::RST_A1;
			coef_q.a2 <= shpf_pkg::RST_A2;
		end else if (wr_en) begin
			unique case (wr_index)
				shpf_pkg::REG_B0: coef_q.b0 <= wr_data;
				shpf_pkg::REG_B1: coef_q.b1 <= wr_data;
				shpf_pkg::REG_B2: coef_q.b2 <= wr_data;
				shpf_pkg::REG_A1: coef_q.a1 <= wr_data;
				shpf_pkg::REG_A2: coef_q.a2 <= wr_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

>>> hdl/shpf_biquad.sv
// saturating biquad datapath with its double-precision history
// uses shpf_pkg
module shpf_biquad (
	input  logic              clk,
	input  logic              arst_n,
	input  shpf_pkg::coef_t   coef,
	input  shpf_pkg::sample_t x0,
	input  logic              upd,
	output shpf_pkg::sample_t res
);

	localparam logic signed [33:0] MAX_L = 34'sd2147483647;
	localparam logic signed [33:0] MIN_L = -34'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > MAX_L) r = 32'sh7FFF_FFFF;
		else if (v < MIN_L) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [33:0] s;
		s = 34'(a) + 34'(b);
		return sat32(s);
	endfunction

	// fractional 16x16 multiply, only -1 * -1 overflows
	function automatic logic signed [31:0] lmult(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [31:0] p;
		logic signed [31:0] r;
		p = a * b;
		if (a == 16'sh8000 && b == 16'sh8000) r = 32'sh7FFF_FFFF;
		else r = {p[30:0], 1'b0};
		return r;
	endfunction

	// hi/lo double precision times 16-bit coefficient
	function automatic logic signed [31:0] mpy(input logic signed [15:0] hi,
		input logic [14:0] lo, input logic signed [15:0] n);
		logic signed [31:0] p;
		logic signed [31:0] m2;
		p  = $signed({1'b0, lo}) * n;
		m2 = {{15{p[30]}}, p[30:15], 1'b0};
		return sat_add(lmult(hi, n), m2);
	endfunction

	shpf_pkg::sample_t x1_q, x2_q;
	logic signed [15:0] y1_hi_q, y2_hi_q;
	logic [14:0]        y1_lo_q, y2_lo_q;

	logic signed [31:0] acc_fb, acc_b0, acc_b1, acc_b2, acc_q15, acc_out, y_rnd;

	always_comb begin
		acc_fb  = sat_add(mpy(y1_hi_q, y1_lo_q, coef.a1), mpy(y2_hi_q, y2_lo_q, coef.a2));
		acc_b0  = sat_add(acc_fb, lmult(x0, coef.b0));
		acc_b1  = sat_add(acc_b0, lmult(x1_q, coef.b1));
		acc_b2  = sat_add(acc_b1, lmult(x2_q, coef.b2));
		// q13 to q15, then x2 output gain
		acc_q15 = sat32(34'(acc_b2) <<< 2);
		acc_out = sat32(34'(acc_q15) <<< 1);
		y_rnd   = sat_add(acc_out, 32'sh0000_8000);
	end

	assign res = y_rnd[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q    <= '0;
			x2_q    <= '0;
			y1_hi_q <= '0;
			y1_lo_q <= '0;
			y2_hi_q <= '0;
			y2_lo_q <= '0;
		end else if (upd) begin
			x2_q    <= x1_q;
			x1_q    <= x0;
			y2_hi_q <= y1_hi_q;
			y2_lo_q <= y1_lo_q;
			y1_hi_q <= acc_q15[31:16];
			y1_lo_q <= acc_q15[15:1];
		end
	end

endmodule

>>> hdl/speech_highpass_postfilter_unit.sv
// Speech high-pass post-filter: 100 Hz biquad in saturating Q13 fixed point with x2 gain.
// One sample word is accepted per clock unless out_ready holds the result register; each
// accepted word is registered in the input register, then in the result register. The rate is
// set by the history feedback, which closes combinationally through the biquad datapath.
// Depends on shpf_pkg, shpf_coef_regs, shpf_biquad and the assertion header.
`include "speech_highpass_postfilter_unit_defines.svh"

module speech_highpass_postfilter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [shpf_pkg::INDEX_W-1:0]  wr_index,
	input  logic [shpf_pkg::COEF_W-1:0]   wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            sample_in,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [15:0]            sample_out,
	output logic                          last_out
);

	shpf_pkg::coef_t   coef;
	shpf_pkg::sample_t sample_s1;
	shpf_pkg::sample_t res;
	logic              last_s1, valid_s1;
	logic              res_valid_q, res_last_q;
	shpf_pkg::sample_t res_sample_q;
	logic              advance;

	// stage 1 moves into the result register when that register is free or drained
	assign advance  = !res_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	shpf_coef_regs u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coef     (coef)
	);

	shpf_biquad u_biquad (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef),
		.x0     (sample_s1),
		.upd    (valid_s1 && advance),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample_in;
			last_s1   <= last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_sample_q <= res;
			res_last_q   <= last_s1;
		end
	end

	assign out_valid  = res_valid_q;
	assign sample_out = res_sample_q;
	assign last_out   = res_last_q;

	`SHPF_ASSERT_NEXT(a_in_lands_s1, in_valid && in_ready, valid_s1)
	`SHPF_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(sample_s1))
	`SHPF_ASSERT_NEXT(a_s1_to_result, valid_s1 && advance, res_valid_q)
	`SHPF_ASSERT_NOW(a_ready_when_empty, !valid_s1, in_ready)

endmodule
